// File: design/lpht_pkg.sv
// Shared types, widths and codes for the linear probing hash table.
`default_nettype none

package lpht_pkg;

  // Field widths
  localparam int KEY_W    = 31;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int SIZE_W   = 5;

  // Largest size the table_size register can name
  localparam int SIZE_MAX = (1 << SIZE_W) - 1;

  localparam int SLOTS_DEF = 16;
  localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = SIZE_W'(16);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_INSERTED = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_FOUND    = 3'd2,
    STAT_NOTFOUND = 3'd3,
    STAT_DELETED  = 3'd4,
    STAT_EMPTY    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_DONE
  } state_t;

  // Remainder unit status
  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

  // Slot store update request
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [SIZE_W-1:0] pos;
  } store_cmd_t;

endpackage

`default_nettype wire

// File: design/lpht_req_if.sv
// Request channel: command and key with valid/ready handshake.
`default_nettype none

interface lpht_req_if
  import lpht_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [KEY_W-1:0] key;

  modport source (output valid, output cmd, output key, input ready);
  modport sink   (input valid, input cmd, input key, output ready);
endinterface

`default_nettype wire

// File: design/lpht_rsp_if.sv
// Response channel: status and slot with valid/ready handshake.
`default_nettype none

interface lpht_rsp_if
  import lpht_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;

  modport source (output valid, output status, output slot, input ready);
  modport sink   (input valid, input status, input slot, output ready);
endinterface

`default_nettype wire

// File: design/linear_probe_hash_table_unit.sv
// Top level of the linear probing hash table.
//
// Open-addressing hash table of 31-bit keys with linear probing. Each request
// is an insert, search or delete and yields one response with a status and a
// slot. The home slot is the key modulo the size in use (table_size, with 0
// taken as 1 and values above the slot count clamped). A request that needs
// probing is hashed by a bit-serial remainder unit (31 steps of one key bit
// each), then probes slot by slot (1 up to the size in use slots), then
// loads the output register. Full, empty and unknown-command requests skip
// hashing and probing. One request is in flight at a time; the next request is
// accepted once the response sits in the output register. Only the first 31
// slots can ever be addressed, so storage is min(SLOTS, 31) entries, all
// marked empty at reset with no clearing pass. Write table_size only while idle.
`default_nettype none

module linear_probe_hash_table_unit
  import lpht_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              table_size_we,
  input  wire logic [SIZE_W-1:0] table_size_wdata,
  lpht_req_if.sink               req,
  lpht_rsp_if.source             rsp
);

  localparam int DEPTH = (SLOTS < SIZE_MAX) ? SLOTS : SIZE_MAX;

  logic [SIZE_W-1:0] table_size;
  logic [SIZE_W-1:0] n_cur;
  logic [SIZE_W-1:0] fill;
  logic              mod_start;
  mod_stat_t         mod_stat;
  logic [SIZE_W-1:0] mod_rem;
  logic [SIZE_W-1:0] probe_pos;
  logic              rd_valid;
  logic [KEY_W-1:0]  rd_key;
  store_cmd_t        wr;
  logic [KEY_W-1:0]  wr_key;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= TABLE_SIZE_RST;
    end else if (table_size_we) begin
      table_size <= table_size_wdata;
    end
  end

  // Clamp the size in use to 1..DEPTH
  always_comb begin
    if (table_size == '0) begin
      n_cur = SIZE_W'(1);
    end else if (table_size > SIZE_W'(DEPTH)) begin
      n_cur = SIZE_W'(DEPTH);
    end else begin
      n_cur = table_size;
    end
  end

  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .n_cur     (n_cur),
    .fill      (fill),
    .mod_start (mod_start),
    .mod_stat  (mod_stat),
    .mod_rem   (mod_rem),
    .probe_pos (probe_pos),
    .rd_valid  (rd_valid),
    .rd_key    (rd_key),
    .wr        (wr),
    .wr_key    (wr_key)
  );

  lpht_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (req.key),
    .divisor  (n_cur),
    .stat     (mod_stat),
    .rem      (mod_rem)
  );

  lpht_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .wr_key   (wr_key),
    .rd_pos   (probe_pos),
    .rd_valid (rd_valid),
    .rd_key   (rd_key),
    .fill     (fill)
  );

  // Fill count never exceeds the storage depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= SIZE_W'(DEPTH))
    else $error("fill count exceeds storage depth");

  // A request is only taken while the remainder unit is idle
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !mod_stat.busy)
    else $error("request accepted while hashing");

  // An insert only lands in an empty slot
  a_insert_empty: assert property (@(posedge clk) disable iff (rst)
    wr.ins |-> !rd_valid)
    else $error("insert overwrote an occupied slot");

  // A delete never hits an empty table and clears exactly one entry
  a_delete_fill: assert property (@(posedge clk) disable iff (rst)
    wr.del |-> (fill != '0) ##1 (fill == $past(fill) - SIZE_W'(1)))
    else $error("delete with inconsistent fill count");

endmodule

`default_nettype wire

// File: design/lpht_mod.sv
// Bit-serial remainder unit: key modulo table size, one key bit per cycle.
`default_nettype none

module lpht_mod
  import lpht_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [KEY_W-1:0]  dividend,
  input  wire logic [SIZE_W-1:0] divisor,
  output mod_stat_t              stat,
  output logic [SIZE_W-1:0]      rem
);

  localparam int CNT_W = $clog2(KEY_W);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [KEY_W-1:0] shreg;
  logic [SIZE_W-1:0] dvs;
  logic [SIZE_W:0]  trial;
  logic [SIZE_W-1:0] rem_next;

  // One restoring step: shift in the next key bit, subtract if it fits
  always_comb begin
    trial = {rem, shreg[KEY_W-1]};
    if (trial >= {1'b0, dvs}) begin
      rem_next = SIZE_W'(trial - {1'b0, dvs});
    end else begin
      rem_next = trial[SIZE_W-1:0];
    end
  end

  // Control: run KEY_W steps after start, then pulse done
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(KEY_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + CNT_W'(1);
        end
      end
    end
  end

  // Datapath: load operands, advance the partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      dvs   <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[KEY_W-2:0], 1'b0};
      rem   <= rem_next;
    end
  end

  assign stat = {busy, done};

endmodule

`default_nettype wire

// File: design/lpht_store.sv
// Slot store: stored keys, per-slot valid bits and the fill count.
`default_nettype none

module lpht_store
  import lpht_pkg::*;
#(
  parameter int DEPTH = SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire store_cmd_t        wr,
  input  wire logic [KEY_W-1:0]  wr_key,
  input  wire logic [SIZE_W-1:0] rd_pos,
  output logic                   rd_valid,
  output logic [KEY_W-1:0]       rd_key,
  output logic [SIZE_W-1:0]      fill
);

  localparam int IDX_W = $clog2(DEPTH);

  logic [KEY_W-1:0] keys [DEPTH];
  logic [DEPTH-1:0] valid;

  // Valid bits and fill count, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      fill  <= '0;
    end else if (wr.ins) begin
      valid[wr.pos[IDX_W-1:0]] <= 1'b1;
      fill <= fill + SIZE_W'(1);
    end else if (wr.del) begin
      valid[wr.pos[IDX_W-1:0]] <= 1'b0;
      fill <= fill - SIZE_W'(1);
    end
  end

  // Key storage
  always_ff @(posedge clk) begin
    if (wr.ins) begin
      keys[wr.pos[IDX_W-1:0]] <= wr_key;
    end
  end

  // Registered read of the requested slot, ready in the following cycle
  always_ff @(posedge clk) begin
    rd_valid <= valid[rd_pos[IDX_W-1:0]];
    rd_key   <= keys[rd_pos[IDX_W-1:0]];
  end

endmodule

`default_nettype wire

// File: design/lpht_ctrl.sv
// Sequencer: accepts a request, hashes, probes slot by slot, holds the response.
`default_nettype none

module lpht_ctrl
  import lpht_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  lpht_req_if.sink               req,
  lpht_rsp_if.source             rsp,
  input  wire logic [SIZE_W-1:0] n_cur,
  input  wire logic [SIZE_W-1:0] fill,
  output logic                   mod_start,
  input  wire mod_stat_t         mod_stat,
  input  wire logic [SIZE_W-1:0] mod_rem,
  output logic [SIZE_W-1:0]      probe_pos,
  input  wire logic              rd_valid,
  input  wire logic [KEY_W-1:0]  rd_key,
  output store_cmd_t             wr,
  output logic [KEY_W-1:0]       wr_key
);

  state_t              state;
  state_t              state_next;
  logic [CMD_W-1:0]    cmd_q;
  logic [KEY_W-1:0]    key_q;
  logic [SIZE_W-1:0]   n_q;
  logic [SIZE_W-1:0]   pos;
  logic [SIZE_W-1:0]   pos_adv;
  logic [SIZE_W-1:0]   count;
  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot;

  logic                early;
  logic [STATUS_W-1:0] early_status;
  logic                key_hit;
  logic                hit;
  logic                last;
  logic                out_free;
  logic                load_out;
  logic                accept;

  // Decide requests that need no probing
  always_comb begin
    early        = 1'b0;
    early_status = STAT_NOTFOUND;
    case (req.cmd)
      CMD_INSERT: begin
        early        = (fill >= n_cur);
        early_status = STAT_FULL;
      end
      CMD_SEARCH: begin
        early = 1'b0;
      end
      CMD_DELETE: begin
        early        = (fill == '0);
        early_status = STAT_EMPTY;
      end
      default: begin
        early = 1'b1;
      end
    endcase
  end

  // Probe outcome for the current slot
  assign key_hit = rd_valid && (rd_key == key_q);
  assign hit     = (cmd_q == CMD_INSERT) ? !rd_valid : key_hit;
  assign last    = (count == n_q - SIZE_W'(1));
  assign out_free = !out_valid || rsp.ready;
  assign pos_adv = (pos == n_q - SIZE_W'(1)) ? '0 : pos + SIZE_W'(1);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = early ? S_DONE : S_HASH;
        end
      end
      S_HASH: begin
        if (mod_stat.done) begin
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (hit || last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control outputs
  always_comb begin
    req.ready = 1'b0;
    mod_start = 1'b0;
    load_out  = 1'b0;
    wr.ins    = 1'b0;
    wr.del    = 1'b0;
    wr.pos    = pos;
    case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        mod_start = req.valid && !early;
      end
      S_PROBE: begin
        wr.ins = (cmd_q == CMD_INSERT) && !rd_valid;
        wr.del = (cmd_q == CMD_DELETE) && key_hit;
      end
      S_DONE: begin
        load_out = out_free;
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  assign accept    = req.valid && req.ready;
  assign wr_key    = key_q;

  // Address the slot probed next cycle; the store registers the read of it
  assign probe_pos = (state == S_HASH) ? mod_rem : pos_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the request, walk the probe sequence, record the outcome
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q      <= req.cmd;
      key_q      <= req.key;
      n_q        <= n_cur;
      res_status <= early_status;
      res_slot   <= '0;
    end else if (state == S_HASH && mod_stat.done) begin
      pos   <= mod_rem;
      count <= '0;
    end else if (state == S_PROBE) begin
      if (hit) begin
        case (cmd_q)
          CMD_INSERT: res_status <= STAT_INSERTED;
          CMD_SEARCH: res_status <= STAT_FOUND;
          CMD_DELETE: res_status <= STAT_DELETED;
          default:    res_status <= STAT_NOTFOUND;
        endcase
        res_slot <= pos[SLOT_W-1:0];
      end else if (last) begin
        res_status <= STAT_NOTFOUND;
        res_slot   <= '0;
      end else begin
        pos   <= pos_adv;
        count <= count + SIZE_W'(1);
      end
    end
  end

  // Output register: hold the response until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= res_status;
      out_slot   <= res_slot;
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.status = out_status;
  assign rsp.slot   = out_slot;

endmodule

`default_nettype wire
